// ===== sv/sip_pkg.sv =====
`timescale 1ns / 1ps

package sip_pkg;

   // Coordinate width and the widths that follow from it.
   localparam int CW   = 24;            // coordinate
   localparam int DW   = CW + 1;        // difference of two coordinates
   localparam int PW   = 2 * DW;        // product of two differences
   localparam int TW   = PW + 1;        // cross or dot product
   localparam int UW   = TW;            // magnitude of a cross product
   localparam int DENW = UW + 1;        // sum of two magnitudes
   localparam int MW   = DW;            // magnitude of a span of segment B
   localparam int QW   = DW;            // quotient bits, one per divider step
   localparam int LOW  = (UW + 1) / 2;  // low slice of the wide multiplicand
   localparam int HIW  = UW - LOW;      // high slice of the wide multiplicand
   localparam int NW   = UW + MW;       // dividend

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
   } point_type;

   typedef struct packed {
      point_type a1;
      point_type a2;
      point_type b1;
      point_type b2;
   } pair_type;

   // Side information that travels with a request through the divider.
   typedef struct packed {
      point_type a1;
      point_type a2;
      point_type b1;
      logic      neg_x;
      logic      neg_y;
      logic      miss;
   } ctx_type;

   // Partial remainder, and a shift register that holds the dividend bits
   // still to come in its upper part and the quotient bits found so far in
   // its lower part.
   typedef struct packed {
      logic [DENW-1:0] rem;
      logic [QW-1:0]   nq;
   } lane_type;

   function automatic logic signed [DW-1:0] sub_ext(input logic signed [CW-1:0] a,
                                                    input logic signed [CW-1:0] b);
      return {a[CW-1], a} - {b[CW-1], b};
   endfunction

   function automatic logic [MW-1:0] mag(input logic signed [DW-1:0] v);
      return v[DW-1] ? -v : v;
   endfunction

   function automatic logic signed [TW-1:0] wide_sub(input logic signed [PW-1:0] a,
                                                     input logic signed [PW-1:0] b);
      return {a[PW-1], a} - {b[PW-1], b};
   endfunction

   function automatic logic signed [TW-1:0] wide_add(input logic signed [PW-1:0] a,
                                                     input logic signed [PW-1:0] b);
      return {a[PW-1], a} + {b[PW-1], b};
   endfunction

   // True when the two values have the same sign, taking zero as a sign.
   function automatic logic same_sign(input logic signed [TW-1:0] a,
                                      input logic signed [TW-1:0] b);
      return (a[TW-1] == b[TW-1]) && ((a == '0) == (b == '0));
   endfunction

   // One restoring division step.
   function automatic lane_type div_step(input lane_type l, input logic [DENW-1:0] d);
      logic [DENW:0] cat;
      logic [DENW:0] diff;
      lane_type      r;
      cat  = {l.rem, l.nq[QW-1]};
      diff = cat - {1'b0, d};
      if (!diff[DENW]) begin
         r.rem = diff[DENW-1:0];
      end else begin
         r.rem = cat[DENW-1:0];
      end
      r.nq = {l.nq[QW-2:0], !diff[DENW]};
      return r;
   endfunction

endpackage

// ===== sv/segment_intersection_point.sv =====
`timescale 1ns / 1ps

// Tests whether segment A (a_start to a_end) crosses segment B (b_start to
// b_end), all coordinates signed Q16.8, and returns the crossing point with
// each axis rounded toward b_start, or hit low and zero coordinates on a miss
// (collinear and parallel segments miss). The block takes one request per
// clock while req_ready is high and returns the results in order:
// six stages form the cross products and the dividends, a 25-stage restoring
// divider produces one quotient bit per stage for both axes, and four stages
// place the point on B and check it against the ends of A. When a result is
// held on the output, the whole pipeline holds with it and req_ready drops.
module segment_intersection_point (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [sip_pkg::CW-1:0] req_seg_a_start_x,
   input  logic signed [sip_pkg::CW-1:0] req_seg_a_start_y,
   input  logic signed [sip_pkg::CW-1:0] req_seg_a_end_x,
   input  logic signed [sip_pkg::CW-1:0] req_seg_a_end_y,
   input  logic signed [sip_pkg::CW-1:0] req_seg_b_start_x,
   input  logic signed [sip_pkg::CW-1:0] req_seg_b_start_y,
   input  logic signed [sip_pkg::CW-1:0] req_seg_b_end_x,
   input  logic signed [sip_pkg::CW-1:0] req_seg_b_end_y,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic signed [sip_pkg::CW-1:0] rsp_cross_x,
   output logic signed [sip_pkg::CW-1:0] rsp_cross_y
);

   logic                     advance;
   sip_pkg::pair_type        pair;
   logic                     front_valid, div_valid;
   sip_pkg::ctx_type         front_ctx, div_ctx;
   logic [sip_pkg::DENW-1:0] front_den;
   sip_pkg::lane_type        front_lane_x, front_lane_y;
   logic [sip_pkg::QW-1:0]   div_qx, div_qy;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   assign pair.a1.x = req_seg_a_start_x;
   assign pair.a1.y = req_seg_a_start_y;
   assign pair.a2.x = req_seg_a_end_x;
   assign pair.a2.y = req_seg_a_end_y;
   assign pair.b1.x = req_seg_b_start_x;
   assign pair.b1.y = req_seg_b_start_y;
   assign pair.b2.x = req_seg_b_end_x;
   assign pair.b2.y = req_seg_b_end_y;

   sip_front u_front (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_valid),
      .in_pair    (pair),
      .out_valid  (front_valid),
      .out_ctx    (front_ctx),
      .out_den    (front_den),
      .out_lane_x (front_lane_x),
      .out_lane_y (front_lane_y)
   );

   sip_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (front_valid),
      .in_ctx    (front_ctx),
      .in_den    (front_den),
      .in_lane_x (front_lane_x),
      .in_lane_y (front_lane_y),
      .out_valid (div_valid),
      .out_ctx   (div_ctx),
      .out_qx    (div_qx),
      .out_qy    (div_qy)
   );

   sip_back u_back (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (div_valid),
      .in_ctx    (div_ctx),
      .in_qx     (div_qx),
      .in_qy     (div_qy),
      .out_valid (rsp_valid),
      .out_hit   (rsp_hit),
      .out_x     (rsp_cross_x),
      .out_y     (rsp_cross_y)
   );

endmodule

// ===== sv/sip_front.sv =====
`timescale 1ns / 1ps

module sip_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       in_valid,
   input  sip_pkg::pair_type          in_pair,
   output logic                       out_valid,
   output sip_pkg::ctx_type           out_ctx,
   output logic [sip_pkg::DENW-1:0]   out_den,
   output sip_pkg::lane_type          out_lane_x,
   output sip_pkg::lane_type          out_lane_y
);

   logic [5:0] vld_ff;

   // Stage 1: differences.
   sip_pkg::ctx_type ctx1_in, ctx1_ff;
   logic signed [sip_pkg::DW-1:0] ax_in, ay_in, d1x_in, d1y_in, d2x_in, d2y_in, bx_in, by_in;
   logic signed [sip_pkg::DW-1:0] ax_ff, ay_ff, d1x_ff, d1y_ff, d2x_ff, d2y_ff, bx_ff, by_ff;

   // Stage 2: products for both cross products, span magnitudes.
   sip_pkg::ctx_type ctx2_in, ctx2_ff;
   logic signed [sip_pkg::PW-1:0] m1_in, m2_in, m3_in, m4_in;
   logic signed [sip_pkg::PW-1:0] m1_ff, m2_ff, m3_ff, m4_ff;
   logic [sip_pkg::MW-1:0] mbx2_in, mby2_in, mbx2_ff, mby2_ff;

   // Stage 3: cross products.
   sip_pkg::ctx_type ctx3_ff;
   logic signed [sip_pkg::TW-1:0] t1_in, t2_in, t1_ff, t2_ff;
   logic [sip_pkg::MW-1:0] mbx3_ff, mby3_ff;

   // Stage 4: magnitudes and the early miss.
   sip_pkg::ctx_type ctx4_in, ctx4_ff;
   logic [sip_pkg::UW-1:0] u1_in, u2_in, u1_ff, u2_ff;
   logic [sip_pkg::MW-1:0] mbx4_ff, mby4_ff;

   // Stage 5: divisor and partial products of the dividends.
   sip_pkg::ctx_type ctx5_ff;
   logic [sip_pkg::DENW-1:0] den5_in, den5_ff;
   logic [sip_pkg::LOW+sip_pkg::MW-1:0] pxl_in, pyl_in, pxl_ff, pyl_ff;
   logic [sip_pkg::HIW+sip_pkg::MW-1:0] pxh_in, pyh_in, pxh_ff, pyh_ff;

   // Stage 6: dividends.
   sip_pkg::ctx_type ctx6_ff;
   logic [sip_pkg::DENW-1:0] den6_ff;
   logic [sip_pkg::NW-1:0] numx_in, numy_in, numx_ff, numy_ff;

   always_comb begin
      ctx1_in.a1    = in_pair.a1;
      ctx1_in.a2    = in_pair.a2;
      ctx1_in.b1    = in_pair.b1;
      ctx1_in.neg_x = 1'b0;
      ctx1_in.neg_y = 1'b0;
      ctx1_in.miss  = 1'b0;
      ax_in  = sip_pkg::sub_ext(in_pair.a2.x, in_pair.a1.x);
      ay_in  = sip_pkg::sub_ext(in_pair.a2.y, in_pair.a1.y);
      d1x_in = sip_pkg::sub_ext(in_pair.b1.x, in_pair.a1.x);
      d1y_in = sip_pkg::sub_ext(in_pair.b1.y, in_pair.a1.y);
      d2x_in = sip_pkg::sub_ext(in_pair.b2.x, in_pair.a1.x);
      d2y_in = sip_pkg::sub_ext(in_pair.b2.y, in_pair.a1.y);
      bx_in  = sip_pkg::sub_ext(in_pair.b2.x, in_pair.b1.x);
      by_in  = sip_pkg::sub_ext(in_pair.b2.y, in_pair.b1.y);

      ctx2_in       = ctx1_ff;
      ctx2_in.neg_x = bx_ff[sip_pkg::DW-1];
      ctx2_in.neg_y = by_ff[sip_pkg::DW-1];
      m1_in   = ax_ff * d1y_ff;
      m2_in   = ay_ff * d1x_ff;
      m3_in   = ax_ff * d2y_ff;
      m4_in   = ay_ff * d2x_ff;
      mbx2_in = sip_pkg::mag(bx_ff);
      mby2_in = sip_pkg::mag(by_ff);

      t1_in = sip_pkg::wide_sub(m1_ff, m2_ff);
      t2_in = sip_pkg::wide_sub(m3_ff, m4_ff);

      ctx4_in      = ctx3_ff;
      ctx4_in.miss = sip_pkg::same_sign(t1_ff, t2_ff);
      u1_in = t1_ff[sip_pkg::TW-1] ? -t1_ff : t1_ff;
      u2_in = t2_ff[sip_pkg::TW-1] ? -t2_ff : t2_ff;

      den5_in = {1'b0, u1_ff} + {1'b0, u2_ff};
      pxl_in  = u1_ff[sip_pkg::LOW-1:0] * mbx4_ff;
      pxh_in  = u1_ff[sip_pkg::UW-1:sip_pkg::LOW] * mbx4_ff;
      pyl_in  = u1_ff[sip_pkg::LOW-1:0] * mby4_ff;
      pyh_in  = u1_ff[sip_pkg::UW-1:sip_pkg::LOW] * mby4_ff;

      numx_in = {pxh_ff, {sip_pkg::LOW{1'b0}}} + {{sip_pkg::HIW{1'b0}}, pxl_ff};
      numy_in = {pyh_ff, {sip_pkg::LOW{1'b0}}} + {{sip_pkg::HIW{1'b0}}, pyl_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctx1_ff <= ctx1_in;
         ax_ff   <= ax_in;
         ay_ff   <= ay_in;
         d1x_ff  <= d1x_in;
         d1y_ff  <= d1y_in;
         d2x_ff  <= d2x_in;
         d2y_ff  <= d2y_in;
         bx_ff   <= bx_in;
         by_ff   <= by_in;

         ctx2_ff <= ctx2_in;
         m1_ff   <= m1_in;
         m2_ff   <= m2_in;
         m3_ff   <= m3_in;
         m4_ff   <= m4_in;
         mbx2_ff <= mbx2_in;
         mby2_ff <= mby2_in;

         ctx3_ff <= ctx2_ff;
         t1_ff   <= t1_in;
         t2_ff   <= t2_in;
         mbx3_ff <= mbx2_ff;
         mby3_ff <= mby2_ff;

         ctx4_ff <= ctx4_in;
         u1_ff   <= u1_in;
         u2_ff   <= u2_in;
         mbx4_ff <= mbx3_ff;
         mby4_ff <= mby3_ff;

         ctx5_ff <= ctx4_ff;
         den5_ff <= den5_in;
         pxl_ff  <= pxl_in;
         pxh_ff  <= pxh_in;
         pyl_ff  <= pyl_in;
         pyh_ff  <= pyh_in;

         ctx6_ff <= ctx5_ff;
         den6_ff <= den5_ff;
         numx_ff <= numx_in;
         numy_ff <= numy_in;
      end
   end

   // The dividend is below the divisor times two to the quotient width, so
   // its upper part already fits as the starting remainder.
   assign out_valid      = vld_ff[5];
   assign out_ctx        = ctx6_ff;
   assign out_den        = den6_ff;
   assign out_lane_x.rem = {1'b0, numx_ff[sip_pkg::NW-1:sip_pkg::QW]};
   assign out_lane_x.nq  = numx_ff[sip_pkg::QW-1:0];
   assign out_lane_y.rem = {1'b0, numy_ff[sip_pkg::NW-1:sip_pkg::QW]};
   assign out_lane_y.nq  = numy_ff[sip_pkg::QW-1:0];

endmodule

// ===== sv/sip_div.sv =====
`timescale 1ns / 1ps

module sip_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       in_valid,
   input  sip_pkg::ctx_type           in_ctx,
   input  logic [sip_pkg::DENW-1:0]   in_den,
   input  sip_pkg::lane_type          in_lane_x,
   input  sip_pkg::lane_type          in_lane_y,
   output logic                       out_valid,
   output sip_pkg::ctx_type           out_ctx,
   output logic [sip_pkg::QW-1:0]     out_qx,
   output logic [sip_pkg::QW-1:0]     out_qy
);

   logic [sip_pkg::QW-1:0] vld_ff;

   sip_pkg::ctx_type         ctx_src [sip_pkg::QW];
   logic [sip_pkg::DENW-1:0] den_src [sip_pkg::QW];
   sip_pkg::lane_type        lx_src  [sip_pkg::QW];
   sip_pkg::lane_type        ly_src  [sip_pkg::QW];

   sip_pkg::lane_type        lx_in   [sip_pkg::QW];
   sip_pkg::lane_type        ly_in   [sip_pkg::QW];

   sip_pkg::ctx_type         ctx_ff  [sip_pkg::QW];
   logic [sip_pkg::DENW-1:0] den_ff  [sip_pkg::QW];
   sip_pkg::lane_type        lx_ff   [sip_pkg::QW];
   sip_pkg::lane_type        ly_ff   [sip_pkg::QW];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[sip_pkg::QW-2:0], in_valid};
      end
   end

   // One quotient bit per stage for each axis.
   for (genvar s = 0; s < sip_pkg::QW; s++) begin : g_step
      if (s == 0) begin : g_first
         assign ctx_src[s] = in_ctx;
         assign den_src[s] = in_den;
         assign lx_src[s]  = in_lane_x;
         assign ly_src[s]  = in_lane_y;
      end else begin : g_next
         assign ctx_src[s] = ctx_ff[s-1];
         assign den_src[s] = den_ff[s-1];
         assign lx_src[s]  = lx_ff[s-1];
         assign ly_src[s]  = ly_ff[s-1];
      end

      assign lx_in[s] = sip_pkg::div_step(lx_src[s], den_src[s]);
      assign ly_in[s] = sip_pkg::div_step(ly_src[s], den_src[s]);

      always_ff @(posedge clock) begin
         if (advance) begin
            ctx_ff[s] <= ctx_src[s];
            den_ff[s] <= den_src[s];
            lx_ff[s]  <= lx_in[s];
            ly_ff[s]  <= ly_in[s];
         end
      end
   end

   assign out_valid = vld_ff[sip_pkg::QW-1];
   assign out_ctx   = ctx_ff[sip_pkg::QW-1];
   assign out_qx    = lx_ff[sip_pkg::QW-1].nq;
   assign out_qy    = ly_ff[sip_pkg::QW-1].nq;

endmodule

// ===== sv/sip_back.sv =====
`timescale 1ns / 1ps

module sip_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  sip_pkg::ctx_type              in_ctx,
   input  logic [sip_pkg::QW-1:0]        in_qx,
   input  logic [sip_pkg::QW-1:0]        in_qy,
   output logic                          out_valid,
   output logic                          out_hit,
   output logic signed [sip_pkg::CW-1:0] out_x,
   output logic signed [sip_pkg::CW-1:0] out_y
);

   logic [3:0] vld_ff;

   // Stage 1: crossing point on the line of B.
   sip_pkg::ctx_type ctx1_ff;
   logic [sip_pkg::DW-1:0] sx_in, sy_in;
   sip_pkg::point_type p1_in, p1_ff;

   // Stage 2: differences for the dot products.
   logic miss2_ff, miss3_ff;
   sip_pkg::point_type p2_ff, p3_ff;
   logic signed [sip_pkg::DW-1:0] ax_in, ay_in, e1x_in, e1y_in, e2x_in, e2y_in;
   logic signed [sip_pkg::DW-1:0] ax_ff, ay_ff, e1x_ff, e1y_ff, e2x_ff, e2y_ff;

   // Stage 3: products.
   logic signed [sip_pkg::PW-1:0] n1_in, n2_in, n3_in, n4_in;
   logic signed [sip_pkg::PW-1:0] n1_ff, n2_ff, n3_ff, n4_ff;

   // Stage 4: result register.
   logic signed [sip_pkg::TW-1:0] v1, v2;
   logic hit_in, hit_ff;
   logic signed [sip_pkg::CW-1:0] x_in, y_in, x_ff, y_ff;

   always_comb begin
      // The quotient never exceeds the span, so the point stays between the
      // ends of B and fits a coordinate.
      sx_in = in_ctx.neg_x ? {in_ctx.b1.x[sip_pkg::CW-1], in_ctx.b1.x} - in_qx
                           : {in_ctx.b1.x[sip_pkg::CW-1], in_ctx.b1.x} + in_qx;
      sy_in = in_ctx.neg_y ? {in_ctx.b1.y[sip_pkg::CW-1], in_ctx.b1.y} - in_qy
                           : {in_ctx.b1.y[sip_pkg::CW-1], in_ctx.b1.y} + in_qy;
      p1_in.x = sx_in[sip_pkg::CW-1:0];
      p1_in.y = sy_in[sip_pkg::CW-1:0];

      ax_in  = sip_pkg::sub_ext(ctx1_ff.a2.x, ctx1_ff.a1.x);
      ay_in  = sip_pkg::sub_ext(ctx1_ff.a2.y, ctx1_ff.a1.y);
      e1x_in = sip_pkg::sub_ext(p1_ff.x, ctx1_ff.a1.x);
      e1y_in = sip_pkg::sub_ext(p1_ff.y, ctx1_ff.a1.y);
      e2x_in = sip_pkg::sub_ext(p1_ff.x, ctx1_ff.a2.x);
      e2y_in = sip_pkg::sub_ext(p1_ff.y, ctx1_ff.a2.y);

      n1_in = ax_ff * e1x_ff;
      n2_in = ay_ff * e1y_ff;
      n3_in = ax_ff * e2x_ff;
      n4_in = ay_ff * e2y_ff;

      v1     = sip_pkg::wide_add(n1_ff, n2_ff);
      v2     = sip_pkg::wide_add(n3_ff, n4_ff);
      hit_in = !miss3_ff && !sip_pkg::same_sign(v1, v2);
      x_in   = hit_in ? p3_ff.x : '0;
      y_in   = hit_in ? p3_ff.y : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctx1_ff  <= in_ctx;
         p1_ff    <= p1_in;

         miss2_ff <= ctx1_ff.miss;
         p2_ff    <= p1_ff;
         ax_ff    <= ax_in;
         ay_ff    <= ay_in;
         e1x_ff   <= e1x_in;
         e1y_ff   <= e1y_in;
         e2x_ff   <= e2x_in;
         e2y_ff   <= e2y_in;

         miss3_ff <= miss2_ff;
         p3_ff    <= p2_ff;
         n1_ff    <= n1_in;
         n2_ff    <= n2_in;
         n3_ff    <= n3_in;
         n4_ff    <= n4_in;

         hit_ff   <= hit_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
      end
   end

   assign out_valid = vld_ff[3];
   assign out_hit   = hit_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;

endmodule
